>>> rtl/lss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants, types and register codes of the line sensor steering block.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int FULL_SCALE  = 1000;
  localparam int RAW_W       = 16;
  localparam int LEVEL_W     = $clog2(FULL_SCALE + 1);
  localparam int NUM_W       = RAW_W + LEVEL_W;
  localparam int DIV_STAGES  = (LEVEL_W + 1) / 2;
  localparam int NUM_SENSORS = 6;
  localparam int NUM_RULES   = 11;
  localparam int DEAD_W      = 12;
  localparam int SPEED_W     = 8;
  localparam int PAIR_W      = 2 * SPEED_W;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int RULE_W      = 4;

  // Sensor positions, left outer to right outer
  localparam int S_LO = 0;
  localparam int S_LM = 1;
  localparam int S_LI = 2;
  localparam int S_RI = 3;
  localparam int S_RM = 4;
  localparam int S_RO = 5;

  typedef logic [RAW_W-1:0]   raw_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [PAIR_W-1:0]  pair_t;

  localparam level_t LEVEL_HIGH = LEVEL_W'(200);
  localparam level_t LEVEL_LOW  = LEVEL_W'(100);

  localparam logic [RULE_W-1:0] NO_RULE = RULE_W'(NUM_RULES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_MIN   = 3'd0,
    REG_RAW_MAX   = 3'd1,
    REG_DEAD_BAND = 3'd2,
    REG_SPEEDS_AD = 3'd3,
    REG_SPEEDS_EH = 3'd4,
    REG_SPEEDS_IK = 3'd5
  } cfg_reg_t;

endpackage

>>> rtl/line_sensor_steering_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_steering_top
// Normalizes six reflectance samples and picks a motor speed pair by rule.
// ----------------------------------------------------------------------------
// Usage:
//   A frame transaction (frame_valid, frame_stall) carries six raw samples.
//   A result transaction (result_valid, result_stall) carries the motor
//   speeds, the matched rule and the line flags for that frame, in order.
//   Registers are written through cfg_write / cfg_index / cfg_data while no
//   frame is in flight; an unknown index is ignored.
// Pipeline: input register, scaled-sample register, the divider stages,
//   level register and output register. Throughput: one frame per cycle
//   while no result is held. The normalizing divider resolves two quotient
//   bits per pipeline stage for all six lanes at once.
// Reset: rst clears all valid bits and loads the register reset values
//   (raw_min 0, raw_max 65535, dead band and speeds 0).
// Stall: while a result is held by result_stall the whole pipeline holds
//   and frame_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module line_sensor_steering_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             frame_valid,
  output logic                             frame_stall,
  input  logic [15:0]                      raw_left_outer,
  input  logic [15:0]                      raw_left_middle,
  input  logic [15:0]                      raw_left_inner,
  input  logic [15:0]                      raw_right_inner,
  input  logic [15:0]                      raw_right_middle,
  input  logic [15:0]                      raw_right_outer,
  input  logic                             cfg_write,
  input  logic [lss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lss_pkg::CFG_W-1:0]        cfg_data,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [7:0]                       left_speed,
  output logic [7:0]                       right_speed,
  output logic [3:0]                       rule_level,
  output logic                             drive,
  output logic                             right_side,
  output logic [5:0]                       on_line_mask,
  output logic                             intersection,
  output logic                             lost,
  output logic                             past_intersection,
  output logic                             straight_on_line
);

  localparam int NS = lss_pkg::NUM_SENSORS;
  localparam int DS = lss_pkg::DIV_STAGES;

  // Configuration registers
  lss_pkg::raw_t                  raw_min;
  lss_pkg::raw_t                  raw_max;
  logic [lss_pkg::DEAD_W-1:0]     dead_band;
  logic [63:0]                    speeds_a_to_d;
  logic [63:0]                    speeds_e_to_h;
  logic [47:0]                    speeds_i_to_k;
  lss_pkg::raw_t                  span;
  logic                           span_ok;

  // Pipeline registers
  logic                           adv;
  logic                           in_v;
  lss_pkg::raw_t                  in_raw [NS];
  logic                           div_v  [DS+1];
  lss_pkg::num_t                  rem    [DS+1][NS];
  lss_pkg::level_t                quo    [DS+1][NS];
  lss_pkg::num_t                  rem_next [DS][NS];
  lss_pkg::level_t                quo_next [DS][NS];
  lss_pkg::num_t                  num_next [NS];
  logic                           lvl_v;
  lss_pkg::level_t                lvl    [NS];
  lss_pkg::level_t                lvl_next [NS];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_min       <= '0;
      raw_max       <= '1;
      dead_band     <= '0;
      speeds_a_to_d <= '0;
      speeds_e_to_h <= '0;
      speeds_i_to_k <= '0;
    end else if (cfg_write) begin
      unique case (lss_pkg::cfg_reg_t'(cfg_index))
        lss_pkg::REG_RAW_MIN:   raw_min       <= cfg_data[15:0];
        lss_pkg::REG_RAW_MAX:   raw_max       <= cfg_data[15:0];
        lss_pkg::REG_DEAD_BAND: dead_band     <= cfg_data[lss_pkg::DEAD_W-1:0];
        lss_pkg::REG_SPEEDS_AD: speeds_a_to_d <= cfg_data;
        lss_pkg::REG_SPEEDS_EH: speeds_e_to_h <= cfg_data;
        lss_pkg::REG_SPEEDS_IK: speeds_i_to_k <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // Keep the span as a register so the divider does not see the subtract
  always_ff @(posedge clk) begin
    span    <= raw_max - raw_min;
    span_ok <= raw_max > raw_min;
  end

  // Advance the whole pipeline unless the result is held
  assign adv         = !(result_valid && result_stall);
  assign frame_stall = !adv;

  // Capture the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (adv) begin
      in_v <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_raw[lss_pkg::S_LO] <= raw_left_outer;
      in_raw[lss_pkg::S_LM] <= raw_left_middle;
      in_raw[lss_pkg::S_LI] <= raw_left_inner;
      in_raw[lss_pkg::S_RI] <= raw_right_inner;
      in_raw[lss_pkg::S_RM] <= raw_right_middle;
      in_raw[lss_pkg::S_RO] <= raw_right_outer;
    end
  end

  // Clamp, offset and scale each sample
  always_comb begin
    lss_pkg::raw_t v;
    for (int i = 0; i < NS; i++) begin
      v = in_raw[i];
      if (v < raw_min) v = raw_min;
      if (v > raw_max) v = raw_max;
      v = v - raw_min;
      num_next[i] = lss_pkg::NUM_W'(v) * lss_pkg::NUM_W'(lss_pkg::FULL_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_v[0] <= 1'b0;
    end else if (adv) begin
      div_v[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NS; i++) begin
        rem[0][i] <= num_next[i];
        quo[0][i] <= '0;
      end
    end
  end

  // Restoring division, two quotient bits per stage
  always_comb begin
    lss_pkg::num_t   r;
    lss_pkg::level_t q;
    lss_pkg::num_t   dvs;
    int              k;
    for (int s = 0; s < DS; s++) begin
      for (int i = 0; i < NS; i++) begin
        r = rem[s][i];
        q = quo[s][i];
        for (int j = 0; j < 2; j++) begin
          k = lss_pkg::LEVEL_W - 1 - 2 * s - j;
          if (k >= 0) begin
            dvs = lss_pkg::NUM_W'(span) << k;
            if (r >= dvs) begin
              r = r - dvs;
              q = q | (lss_pkg::LEVEL_W'(1) << k);
            end
          end
        end
        rem_next[s][i] = r;
        quo_next[s][i] = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= DS; s++) div_v[s] <= 1'b0;
    end else if (adv) begin
      for (int s = 1; s <= DS; s++) div_v[s] <= div_v[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < DS; s++) begin
        for (int i = 0; i < NS; i++) begin
          rem[s+1][i] <= rem_next[s][i];
          quo[s+1][i] <= quo_next[s][i];
        end
      end
    end
  end

  // Subtract the dead band, saturating at zero; an empty span gives zero
  always_comb begin
    logic [lss_pkg::DEAD_W-1:0] qx;
    for (int i = 0; i < NS; i++) begin
      qx = lss_pkg::DEAD_W'(quo[DS][i]);
      if (span_ok && qx > dead_band) begin
        lvl_next[i] = lss_pkg::LEVEL_W'(qx - dead_band);
      end else begin
        lvl_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_v <= 1'b0;
    end else if (adv) begin
      lvl_v <= div_v[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NS; i++) lvl[i] <= lvl_next[i];
    end
  end

  // Evaluate rules and pick the speed pair
  logic [NS-1:0]                  on;
  logic [lss_pkg::NUM_RULES-1:0]  lm;
  logic [lss_pkg::NUM_RULES-1:0]  rm;
  lss_pkg::pair_t                 pairs [lss_pkg::NUM_RULES];
  logic [lss_pkg::RULE_W-1:0]     rule_next;
  logic                           side_next;
  lss_pkg::pair_t                 pair_sel;
  logic [7:0]                     left_next;
  logic [7:0]                     right_next;

  always_comb begin
    for (int i = 0; i < NS; i++) on[i] = lvl[i] != '0;
  end

  always_comb begin
    lss_pkg::level_t lo, lmv, li, ri, rmv, ro;
    lo  = lvl[lss_pkg::S_LO];
    lmv = lvl[lss_pkg::S_LM];
    li  = lvl[lss_pkg::S_LI];
    ri  = lvl[lss_pkg::S_RI];
    rmv = lvl[lss_pkg::S_RM];
    ro  = lvl[lss_pkg::S_RO];
    lm[0]  = on[lss_pkg::S_LI] && on[lss_pkg::S_RI] && li > lss_pkg::LEVEL_HIGH
             && ri > lss_pkg::LEVEL_HIGH && li > ri;
    rm[0]  = on[lss_pkg::S_LI] && on[lss_pkg::S_RI] && li > lss_pkg::LEVEL_HIGH
             && ri > lss_pkg::LEVEL_HIGH && ri > li;
    lm[1]  = on[lss_pkg::S_LI] && on[lss_pkg::S_RI] && li > ri;
    rm[1]  = on[lss_pkg::S_LI] && on[lss_pkg::S_RI] && ri > li;
    lm[2]  = on[lss_pkg::S_LI] && !on[lss_pkg::S_LM];
    rm[2]  = on[lss_pkg::S_RI] && !on[lss_pkg::S_RM];
    lm[3]  = on[lss_pkg::S_LI] && on[lss_pkg::S_LM] && li > lss_pkg::LEVEL_HIGH && li > lmv;
    rm[3]  = on[lss_pkg::S_RI] && on[lss_pkg::S_RM] && ri > lss_pkg::LEVEL_HIGH && ri > rmv;
    lm[4]  = on[lss_pkg::S_LI] && on[lss_pkg::S_LM] && li > lss_pkg::LEVEL_LOW
             && lmv > lss_pkg::LEVEL_LOW;
    rm[4]  = on[lss_pkg::S_RI] && on[lss_pkg::S_RM] && ri > lss_pkg::LEVEL_LOW
             && rmv > lss_pkg::LEVEL_LOW;
    lm[5]  = on[lss_pkg::S_LI] && on[lss_pkg::S_LM] && lmv > lss_pkg::LEVEL_HIGH && lmv > li;
    rm[5]  = on[lss_pkg::S_RI] && on[lss_pkg::S_RM] && rmv > lss_pkg::LEVEL_HIGH && rmv > ri;
    lm[6]  = on[lss_pkg::S_LM] && !on[lss_pkg::S_LO];
    rm[6]  = on[lss_pkg::S_RM] && !on[lss_pkg::S_RO];
    lm[7]  = on[lss_pkg::S_LM] && on[lss_pkg::S_LO] && lmv > lss_pkg::LEVEL_HIGH && lo > lmv;
    rm[7]  = on[lss_pkg::S_RM] && on[lss_pkg::S_RO] && rmv > lss_pkg::LEVEL_HIGH && ro > rmv;
    lm[8]  = on[lss_pkg::S_LM] && on[lss_pkg::S_LO] && lmv > lss_pkg::LEVEL_LOW
             && lo > lss_pkg::LEVEL_LOW;
    rm[8]  = on[lss_pkg::S_RM] && on[lss_pkg::S_RO] && rmv > lss_pkg::LEVEL_LOW
             && ro > lss_pkg::LEVEL_LOW;
    lm[9]  = on[lss_pkg::S_LM] && on[lss_pkg::S_LO] && lo > lss_pkg::LEVEL_HIGH && lo > lmv;
    rm[9]  = on[lss_pkg::S_RM] && on[lss_pkg::S_RO] && ro > lss_pkg::LEVEL_HIGH && ro > rmv;
    lm[10] = on[lss_pkg::S_LO];
    rm[10] = on[lss_pkg::S_RO];
  end

  // Unpack speed pairs
  always_comb begin
    for (int i = 0; i < 4; i++) pairs[i]     = speeds_a_to_d[16*i +: 16];
    for (int i = 0; i < 4; i++) pairs[4 + i] = speeds_e_to_h[16*i +: 16];
    for (int i = 0; i < 3; i++) pairs[8 + i] = speeds_i_to_k[16*i +: 16];
  end

  // First matching rule wins; scan from the lowest priority up
  always_comb begin
    rule_next = lss_pkg::NO_RULE;
    side_next = 1'b0;
    for (int i = lss_pkg::NUM_RULES - 1; i >= 0; i--) begin
      if (lm[i] || rm[i]) begin
        rule_next = lss_pkg::RULE_W'(i);
        side_next = rm[i];
      end
    end
  end

  always_comb begin
    pair_sel   = '0;
    left_next  = '0;
    right_next = '0;
    if (rule_next != lss_pkg::NO_RULE) begin
      pair_sel = pairs[rule_next];
      if (side_next) begin
        left_next  = pair_sel[15:8];
        right_next = pair_sel[7:0];
      end else begin
        left_next  = pair_sel[7:0];
        right_next = pair_sel[15:8];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= lvl_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_speed        <= left_next;
      right_speed       <= right_next;
      rule_level        <= rule_next;
      drive             <= rule_next != lss_pkg::NO_RULE;
      right_side        <= side_next;
      on_line_mask      <= on;
      intersection      <= &on;
      lost              <= ~|on;
      past_intersection <= !on[lss_pkg::S_LO] && !on[lss_pkg::S_RO];
      straight_on_line  <= on[lss_pkg::S_LI] && on[lss_pkg::S_RI];
    end
  end

  // Checks
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> result_valid && result_stall)
    else $error("frame stalled without a held result");

  a_no_rule_no_speed: assert property (@(posedge clk) disable iff (rst)
    result_valid && !drive |->
      rule_level == lss_pkg::NO_RULE && left_speed == '0 && right_speed == '0)
    else $error("speed issued without a matched rule");

  a_side_needs_drive: assert property (@(posedge clk) disable iff (rst)
    result_valid && right_side |-> drive)
    else $error("right side flagged without a match");

  a_lost_vs_intersection: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(lost && intersection) && (lost == (on_line_mask == '0)))
    else $error("line flags disagree with mask");

endmodule

>>> tb/tb_line_sensor_steering_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_sensor_steering_top
// Drives sensor frames through the steering block under several calibration
// and speed settings, predicts every steering decision and compares it field
// by field. A directed table covers calibration extremes, equal levels, rules
// 0-7 and 10 on both sides and 8 on the left; random frames follow, mostly
// shaped near typical line patterns, under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_line_sensor_steering_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  // Sensor positions, left outer to right outer
  localparam int S_LO = lss_pkg::S_LO;
  localparam int S_LM = lss_pkg::S_LM;
  localparam int S_LI = lss_pkg::S_LI;
  localparam int S_RI = lss_pkg::S_RI;
  localparam int S_RM = lss_pkg::S_RM;
  localparam int S_RO = lss_pkg::S_RO;

  typedef struct packed {
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic [3:0] rule_level;
    logic       drive;
    logic       right_side;
    logic [5:0] on_line_mask;
    logic       intersection;
    logic       lost;
    logic       past_intersection;
    logic       straight_on_line;
  } steer_t;

  typedef struct {
    logic [15:0] raw [6];
    logic        fixed;
    steer_t      want;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic frame_valid = 1'b0;
  logic frame_stall;
  logic [15:0] raw_in [6];
  logic cfg_write = 1'b0;
  logic [lss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lss_pkg::CFG_W-1:0] cfg_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  steer_t got;

  // Shadow calibration
  logic [15:0] cal_min, cal_max;
  logic [11:0] cal_dead;
  logic [63:0] spd_ad, spd_eh;
  logic [47:0] spd_ik;

  steer_t decisions_due [$];
  int errors = 0;
  int idle_pct_send = 0;
  int stall_pct_recv = 0;
  int quiet_cycles = 0;
  logic timed_out = 1'b0;

  always #10 clk = ~clk;

  initial foreach (raw_in[i]) raw_in[i] = '0;

  line_sensor_steering_top i_dut (
    .clk(clk), .rst(rst),
    .frame_valid(frame_valid), .frame_stall(frame_stall),
    .raw_left_outer(raw_in[0]), .raw_left_middle(raw_in[1]),
    .raw_left_inner(raw_in[2]), .raw_right_inner(raw_in[3]),
    .raw_right_middle(raw_in[4]), .raw_right_outer(raw_in[5]),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result_stall(result_stall),
    .left_speed(got.left_speed), .right_speed(got.right_speed),
    .rule_level(got.rule_level), .drive(got.drive), .right_side(got.right_side),
    .on_line_mask(got.on_line_mask), .intersection(got.intersection),
    .lost(got.lost), .past_intersection(got.past_intersection),
    .straight_on_line(got.straight_on_line)
  );

  // Normalize one raw sample into a level above the dead band
  function automatic int unsigned norm_level(logic [15:0] raw);
    int unsigned v, s;
    if (cal_max <= cal_min) return 0;
    v = raw;
    if (v < cal_min) v = cal_min;
    if (v > cal_max) v = cal_max;
    s = ((v - cal_min) * lss_pkg::FULL_SCALE) / (cal_max - cal_min);
    return (s > cal_dead) ? s - cal_dead : 0;
  endfunction

  function automatic steer_t steer_decision(logic [15:0] raw [6]);
    int unsigned lv [6];
    logic on [6];
    logic lhit [11], rhit [11];
    logic [15:0] pair;
    steer_t d;
    int rule;
    for (int i = 0; i < 6; i++) begin
      lv[i] = norm_level(raw[i]);
      on[i] = lv[i] != 0;
    end
    lhit[0] = on[S_LI] && on[S_RI] && lv[S_LI] > 200 && lv[S_RI] > 200 && lv[S_LI] > lv[S_RI];
    rhit[0] = on[S_LI] && on[S_RI] && lv[S_LI] > 200 && lv[S_RI] > 200 && lv[S_RI] > lv[S_LI];
    lhit[1] = on[S_LI] && on[S_RI] && lv[S_LI] > lv[S_RI];
    rhit[1] = on[S_LI] && on[S_RI] && lv[S_RI] > lv[S_LI];
    lhit[2] = on[S_LI] && !on[S_LM];
    rhit[2] = on[S_RI] && !on[S_RM];
    lhit[3] = on[S_LI] && on[S_LM] && lv[S_LI] > 200 && lv[S_LI] > lv[S_LM];
    rhit[3] = on[S_RI] && on[S_RM] && lv[S_RI] > 200 && lv[S_RI] > lv[S_RM];
    lhit[4] = on[S_LI] && on[S_LM] && lv[S_LI] > 100 && lv[S_LM] > 100;
    rhit[4] = on[S_RI] && on[S_RM] && lv[S_RI] > 100 && lv[S_RM] > 100;
    lhit[5] = on[S_LI] && on[S_LM] && lv[S_LM] > 200 && lv[S_LM] > lv[S_LI];
    rhit[5] = on[S_RI] && on[S_RM] && lv[S_RM] > 200 && lv[S_RM] > lv[S_RI];
    lhit[6] = on[S_LM] && !on[S_LO];
    rhit[6] = on[S_RM] && !on[S_RO];
    lhit[7] = on[S_LM] && on[S_LO] && lv[S_LM] > 200 && lv[S_LO] > lv[S_LM];
    rhit[7] = on[S_RM] && on[S_RO] && lv[S_RM] > 200 && lv[S_RO] > lv[S_RM];
    lhit[8] = on[S_LM] && on[S_LO] && lv[S_LM] > 100 && lv[S_LO] > 100;
    rhit[8] = on[S_RM] && on[S_RO] && lv[S_RM] > 100 && lv[S_RO] > 100;
    lhit[9] = on[S_LM] && on[S_LO] && lv[S_LO] > 200 && lv[S_LO] > lv[S_LM];
    rhit[9] = on[S_RM] && on[S_RO] && lv[S_RO] > 200 && lv[S_RO] > lv[S_RM];
    lhit[10] = on[S_LO];
    rhit[10] = on[S_RO];
    d = '0;
    rule = lss_pkg::NUM_RULES;
    for (int i = lss_pkg::NUM_RULES - 1; i >= 0; i--)
      if (lhit[i] || rhit[i]) rule = i;
    for (int i = 0; i < 6; i++) d.on_line_mask[i] = on[i];
    d.rule_level = rule[3:0];
    if (rule != lss_pkg::NUM_RULES) begin
      if (rule < 4) pair = spd_ad[16*rule +: 16];
      else if (rule < 8) pair = spd_eh[16*(rule-4) +: 16];
      else pair = spd_ik[16*(rule-8) +: 16];
      d.drive = 1'b1;
      d.right_side = rhit[rule];
      d.left_speed = d.right_side ? pair[15:8] : pair[7:0];
      d.right_speed = d.right_side ? pair[7:0] : pair[15:8];
    end
    d.intersection = &d.on_line_mask;
    d.lost = ~|d.on_line_mask;
    d.past_intersection = !on[S_LO] && !on[S_RO];
    d.straight_on_line = on[S_LI] && on[S_RI];
    return d;
  endfunction

  task automatic report_mismatch(string what, steer_t w, steer_t g);
    errors++;
    $display("MISMATCH %s: expected %h got %h at %0t", what, w, g, $realtime);
  endtask

  // Check result transactions against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (decisions_due.size() == 0) report_mismatch("unexpected result", '0, got);
      else begin
        steer_t w;
        w = decisions_due.pop_front();
        if (w.left_speed !== got.left_speed) report_mismatch("left_speed", w, got);
        if (w.right_speed !== got.right_speed) report_mismatch("right_speed", w, got);
        if (w.rule_level !== got.rule_level) report_mismatch("rule_level", w, got);
        if (w.drive !== got.drive) report_mismatch("drive", w, got);
        if (w.right_side !== got.right_side) report_mismatch("right_side", w, got);
        if (w.on_line_mask !== got.on_line_mask) report_mismatch("on_line_mask", w, got);
        if (w.intersection !== got.intersection) report_mismatch("intersection", w, got);
        if (w.lost !== got.lost) report_mismatch("lost", w, got);
        if (w.past_intersection !== got.past_intersection)
          report_mismatch("past_intersection", w, got);
        if (w.straight_on_line !== got.straight_on_line)
          report_mismatch("straight_on_line", w, got);
      end
    end
  end

  // Random receiver stall
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct_recv);
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (frame_valid && !frame_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else if (frame_valid || decisions_due.size() != 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("tb_line_sensor_steering_top failed");
      $finish;
    end
  end

  task automatic write_reg(lss_pkg::cfg_reg_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      lss_pkg::REG_RAW_MIN: cal_min = val[15:0];
      lss_pkg::REG_RAW_MAX: cal_max = val[15:0];
      lss_pkg::REG_DEAD_BAND: cal_dead = val[11:0];
      lss_pkg::REG_SPEEDS_AD: spd_ad = val;
      lss_pkg::REG_SPEEDS_EH: spd_eh = val;
      lss_pkg::REG_SPEEDS_IK: spd_ik = val[47:0];
      default: ;
    endcase
  endtask

  // Wait out every pending result plus pipeline depth
  task automatic drain();
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(logic [15:0] raw [6]);
    while ($urandom_range(99) < idle_pct_send) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    foreach (raw_in[i]) raw_in[i] <= raw[i];
    decisions_due.push_back(steer_decision(raw));
    @(posedge clk);
    while (frame_stall) @(posedge clk);
  endtask

  task automatic end_burst();
    frame_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Frame shaped near a line: levels spread around the rule thresholds
  function automatic logic [15:0] shaped_raw();
    int unsigned span;
    span = (cal_max > cal_min) ? cal_max - cal_min : 1;
    case ($urandom_range(4))
      0: return cal_min;
      1: return 16'($urandom);
      default: return 16'(cal_min + (span * $urandom_range(400)) / 1000);
    endcase
  endfunction

  frame_row_t dir_rows [$];

  task automatic add_row(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                         logic [15:0] d, logic [15:0] e, logic [15:0] f,
                         logic fixed, steer_t want);
    frame_row_t r;
    r.raw[0] = a; r.raw[1] = b; r.raw[2] = c;
    r.raw[3] = d; r.raw[4] = e; r.raw[5] = f;
    r.fixed = fixed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  initial begin
    logic [15:0] raw [6];
    steer_t none_lost, all_on;
    cal_min = 16'd0; cal_max = 16'hFFFF; cal_dead = '0;
    spd_ad = '0; spd_eh = '0; spd_ik = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset calibration, then a known speed table
    none_lost = '0;
    none_lost.rule_level = lss_pkg::NO_RULE;
    none_lost.lost = 1'b1;
    none_lost.past_intersection = 1'b1;
    add_row(0, 0, 0, 0, 0, 0, 1'b1, none_lost);
    all_on = '0;
    all_on.drive = 1'b1;
    all_on.rule_level = 4'd0;
    all_on.on_line_mask = 6'h3F;
    all_on.intersection = 1'b1;
    all_on.straight_on_line = 1'b1;
    // all full except right inner at half: rule A left, speeds 0 at reset
    add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1, all_on);
    foreach (dir_rows[k]) begin
      send_frame(dir_rows[k].raw);
      if (dir_rows[k].fixed) decisions_due[decisions_due.size()-1] = dir_rows[k].want;
    end
    end_burst();
    drain();
    dir_rows.delete();

    write_reg(lss_pkg::REG_RAW_MIN, 64'd1000);
    write_reg(lss_pkg::REG_RAW_MAX, 64'd11000);
    write_reg(lss_pkg::REG_DEAD_BAND, 64'd50);
    write_reg(lss_pkg::REG_SPEEDS_AD, 64'h0D0C_0B0A_0908_0706);
    write_reg(lss_pkg::REG_SPEEDS_EH, 64'h1E1D_1C1B_1A19_1817);
    write_reg(lss_pkg::REG_SPEEDS_IK, 64'hFFFF_2F2E_2D2C);
    // rules 0-7 and 10 on both sides, rule 8 on the left, equal levels, clamps, extremes
    add_row(1000, 1000, 9000, 8000, 1000, 1000, 1'b0, '0);
    add_row(1000, 1000, 8000, 9000, 1000, 1000, 1'b0, '0);
    add_row(1000, 1000, 2500, 2000, 1000, 1000, 1'b0, '0);
    add_row(1000, 1000, 2000, 2500, 1000, 1000, 1'b0, '0);
    add_row(1000, 1000, 5000, 5000, 1000, 1000, 1'b0, '0);
    add_row(1000, 1000, 3000, 1000, 1000, 1000, 1'b0, '0);
    add_row(1000, 1000, 1000, 3000, 1000, 1000, 1'b0, '0);
    add_row(1000, 3000, 6000, 1000, 1000, 1000, 1'b0, '0);
    add_row(1000, 1000, 1000, 6000, 3000, 1000, 1'b0, '0);
    add_row(1000, 3000, 3000, 1000, 1000, 1000, 1'b0, '0);
    add_row(1000, 1000, 1000, 3000, 3000, 1000, 1'b0, '0);
    add_row(1000, 6000, 2000, 1000, 1000, 1000, 1'b0, '0);
    add_row(1000, 1000, 1000, 2000, 6000, 1000, 1'b0, '0);
    add_row(1000, 3000, 1000, 1000, 1000, 1000, 1'b0, '0);
    add_row(1000, 1000, 1000, 1000, 3000, 1000, 1'b0, '0);
    add_row(9000, 5000, 1000, 1000, 1000, 1000, 1'b0, '0);
    add_row(1000, 1000, 1000, 1000, 5000, 9000, 1'b0, '0);
    add_row(3000, 3000, 1000, 1000, 1000, 1000, 1'b0, '0);
    add_row(1000, 1000, 1000, 1000, 1700, 2000, 1'b0, '0);
    add_row(1000, 1000, 1000, 1000, 1000, 4000, 1'b0, '0);
    add_row(4000, 1000, 1000, 1000, 1000, 1000, 1'b0, '0);
    add_row(0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 1'b0, '0);
    add_row(16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0, 1'b0, '0);
    foreach (dir_rows[k]) send_frame(dir_rows[k].raw);
    end_burst();
    drain();

    // Random phases over several calibrations
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct_send = 0;  stall_pct_recv = 0;  end
        1: begin idle_pct_send = 76; stall_pct_recv = 0;  end
        2: begin idle_pct_send = 0;  stall_pct_recv = 76; end
        default: begin idle_pct_send = 14; stall_pct_recv = 14; end
      endcase
      case (ph)
        0: begin
          write_reg(lss_pkg::REG_RAW_MIN, 64'd0);
          write_reg(lss_pkg::REG_RAW_MAX, 64'hFFFF);
        end
        3: begin
          write_reg(lss_pkg::REG_RAW_MIN, 64'hFFFF);
          write_reg(lss_pkg::REG_RAW_MAX, 64'h0);
        end
        5: begin
          write_reg(lss_pkg::REG_RAW_MIN, 64'd7);
          write_reg(lss_pkg::REG_RAW_MAX, 64'd7);
        end
        default: begin
          write_reg(lss_pkg::REG_RAW_MIN, 64'($urandom_range(20000)));
          write_reg(lss_pkg::REG_RAW_MAX, 64'($urandom_range(65535, 25000)));
        end
      endcase
      write_reg(lss_pkg::REG_DEAD_BAND, (ph == 6) ? 64'hFFF : 64'($urandom_range(150)));
      write_reg(lss_pkg::REG_SPEEDS_AD, {$urandom, $urandom});
      write_reg(lss_pkg::REG_SPEEDS_EH,
                (ph == 7) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
      write_reg(lss_pkg::REG_SPEEDS_IK, {$urandom, $urandom});
      for (int n = 0; n < 80; n++) begin
        foreach (raw[i]) raw[i] = ($urandom_range(9) == 0) ? 16'($urandom) : shaped_raw();
        send_frame(raw);
        if ($urandom_range(15) == 0) end_burst();
      end
      end_burst();
      drain();
    end

    if (errors == 0 && decisions_due.size() == 0)
      $display("tb_line_sensor_steering_top passed");
    else
      $display("tb_line_sensor_steering_top failed");
    $finish;
  end

endmodule
